// ----- sv/afsk_hdlc_modulator_defines.svh -----
// Assertion macros used by the modulator's top-level RTL file.
`ifndef AFSK_HDLC_MODULATOR_DEFINES_SVH
`define AFSK_HDLC_MODULATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define AHM_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define AHM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/ahm_pkg.sv -----
// Types, constants and helper functions of the AFSK/HDLC modulator.
package ahm_pkg;

	// Command codes on the input port
	typedef enum logic [2:0] {
		CMD_TICK  = 3'd0,
		CMD_DATA  = 3'd1,
		CMD_FLAG  = 3'd2,
		CMD_END   = 3'd3,
		CMD_START = 3'd4
	} cmd_t;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_MARK_STEP  = 2'd0,
		REG_SPACE_STEP = 2'd1,
		REG_AMPLITUDE  = 2'd2,
		REG_SPS        = 2'd3
	} reg_idx_t;

	// Frame closing sequencer
	typedef enum logic [3:0] {
		CLOSE_NONE   = 4'b0001,
		CLOSE_FCS_LO = 4'b0010,
		CLOSE_FCS_HI = 4'b0100,
		CLOSE_FLAG   = 4'b1000
	} close_t;

	// Per-sample status carried alongside each word
	typedef struct packed {
		logic active;
		logic taken;
		logic done;
	} flags_t;

	localparam int FLAGS_W = $bits(flags_t);

	localparam logic [7:0]  FLAG_BYTE = 8'h7e;
	localparam logic [3:0]  BYTE_BITS = 4'd8;
	localparam logic [2:0]  STUFF_RUN = 3'd5;
	localparam logic [15:0] CRC_POLY  = 16'h8408;
	localparam logic [15:0] CRC_INIT  = 16'hffff;

	localparam int SAMPLE_W   = 16;
	localparam int MAG_W      = 15;
	localparam int PROD_W     = 2 * MAG_W;
	localparam logic [MAG_W:0] FULL_SCALE = 16'd32767;

	localparam int SINE_ENTRIES = 64;
	localparam int SINE_BITS    = $clog2(SINE_ENTRIES);
	localparam int POS_BITS     = SINE_BITS + 2;

	// First quadrant of the sine, full scale 32767
	localparam logic [MAG_W-1:0] QUARTER_SINE [SINE_ENTRIES] = '{
		15'd0,     15'd804,   15'd1608,  15'd2410,  15'd3212,  15'd4011,  15'd4808,
		15'd5602,  15'd6393,  15'd7179,  15'd7962,  15'd8739,  15'd9512,  15'd10278,
		15'd11039, 15'd11793, 15'd12539, 15'd13279, 15'd14010, 15'd14732, 15'd15446,
		15'd16151, 15'd16846, 15'd17530, 15'd18204, 15'd18868, 15'd19519, 15'd20159,
		15'd20787, 15'd21403, 15'd22005, 15'd22594, 15'd23170, 15'd23731, 15'd24279,
		15'd24811, 15'd25329, 15'd25832, 15'd26319, 15'd26790, 15'd27245, 15'd27683,
		15'd28105, 15'd28510, 15'd28898, 15'd29268, 15'd29621, 15'd29956, 15'd30273,
		15'd30571, 15'd30852, 15'd31113, 15'd31356, 15'd31580, 15'd31785, 15'd31971,
		15'd32137, 15'd32285, 15'd32412, 15'd32521, 15'd32609, 15'd32678, 15'd32728,
		15'd32757
	};

	// CRC-16/X.25 update by one byte, reflected, LSB first
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// ----- sv/ahm_queue.sv -----
// Small FIFO queue in flip-flops, used between pipeline parts and at the output.
module ahm_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

endmodule

// ----- sv/ahm_front.sv -----
// Front part: command decode, HDLC bit framing, NRZI, symbol timing and phase.
module ahm_front #(
	parameter int PHASE_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  logic [2:0]             cmd,
	input  logic [7:0]             data_byte,
	input  logic                   mid_full,
	input  logic [31:0]            mark_step,
	input  logic [31:0]            space_step,
	input  logic [7:0]             sym_len,
	output logic                   mid_push,
	output logic [PHASE_WIDTH-1:0] mid_phase,
	output ahm_pkg::flags_t        mid_flags
);

	logic [PHASE_WIDTH-1:0] phase_q, n_phase;
	logic                   nrzi_q, n_nrzi;
	logic [2:0]             ones_q, n_ones;
	logic [15:0]            crc_q, n_crc;
	logic [15:0]            fcs_q, n_fcs;
	logic [7:0]             shift_q, n_shift;
	logic [3:0]             bits_q, n_bits;
	logic                   stuff_en_q, n_stuff_en;
	logic                   pend_q, n_pend;
	logic [7:0]             count_q, n_count;
	ahm_pkg::close_t        close_q, n_close;
	logic                   idle, tx_bit;
	ahm_pkg::flags_t        flags;
	logic [PHASE_WIDTH-1:0] phase_out;

	assign mid_push  = push && !mid_full;
	assign mid_phase = phase_out;
	assign mid_flags = flags;

	// next state for one sample tick
	always_comb begin
		n_phase    = phase_q;
		n_nrzi     = nrzi_q;
		n_ones     = ones_q;
		n_crc      = crc_q;
		n_fcs      = fcs_q;
		n_shift    = shift_q;
		n_bits     = bits_q;
		n_stuff_en = stuff_en_q;
		n_pend     = pend_q;
		n_count    = count_q;
		n_close    = close_q;
		tx_bit     = 1'b1;
		flags      = '0;
		idle       = (bits_q == '0) && !pend_q && (count_q == '0) &&
			(close_q == ahm_pkg::CLOSE_NONE);

		// command intake, only with nothing pending
		if (idle) begin
			unique case (cmd)
				ahm_pkg::CMD_DATA: begin
					n_shift    = data_byte;
					n_bits     = ahm_pkg::BYTE_BITS;
					n_stuff_en = 1'b1;
					n_crc      = ahm_pkg::crc16_byte(crc_q, data_byte);
					flags.taken = 1'b1;
				end
				ahm_pkg::CMD_FLAG: begin
					n_shift    = ahm_pkg::FLAG_BYTE;
					n_bits     = ahm_pkg::BYTE_BITS;
					n_stuff_en = 1'b0;
					flags.taken = 1'b1;
				end
				ahm_pkg::CMD_END: begin
					n_fcs      = ~crc_q;
					n_crc      = ahm_pkg::CRC_INIT;
					n_shift    = ~crc_q[7:0];
					n_bits     = ahm_pkg::BYTE_BITS;
					n_stuff_en = 1'b1;
					n_close    = ahm_pkg::CLOSE_FCS_LO;
					flags.taken = 1'b1;
				end
				ahm_pkg::CMD_START: begin
					n_phase    = '0;
					n_nrzi     = 1'b1;
					n_ones     = '0;
					flags.taken = 1'b1;
				end
				default: begin
				end
			endcase
		end

		// start the next bit (stuffed zero first)
		if ((n_count == '0) && (n_pend || (n_bits != '0))) begin
			if (n_pend) begin
				tx_bit = 1'b0;
				n_pend = 1'b0;
				n_ones = '0;
			end else begin
				tx_bit  = n_shift[0];
				n_shift = n_shift >> 1;
				n_bits  = n_bits - 1'b1;
				if (n_stuff_en && tx_bit) begin
					n_ones = n_ones + 1'b1;
					if (n_ones == ahm_pkg::STUFF_RUN) begin
						n_pend = 1'b1;
						n_ones = '0;
					end
				end else begin
					n_ones = '0;
				end
			end
			if (!tx_bit) begin
				n_nrzi = ~n_nrzi;
			end
			n_count = (sym_len == '0) ? 8'd1 : sym_len;
		end

		// one tone sample, then frame close sequencing
		phase_out = n_phase;
		if (n_count != '0) begin
			flags.active = 1'b1;
			n_phase = n_phase + (n_nrzi ? mark_step[PHASE_WIDTH-1:0] :
				space_step[PHASE_WIDTH-1:0]);
			n_count = n_count - 1'b1;
			if ((n_count == '0) && (n_bits == '0) && !n_pend) begin
				unique case (n_close)
					ahm_pkg::CLOSE_FCS_LO: begin
						n_shift    = n_fcs[15:8];
						n_bits     = ahm_pkg::BYTE_BITS;
						n_stuff_en = 1'b1;
						n_close    = ahm_pkg::CLOSE_FCS_HI;
					end
					ahm_pkg::CLOSE_FCS_HI: begin
						n_shift    = ahm_pkg::FLAG_BYTE;
						n_bits     = ahm_pkg::BYTE_BITS;
						n_stuff_en = 1'b0;
						n_close    = ahm_pkg::CLOSE_FLAG;
					end
					ahm_pkg::CLOSE_FLAG: begin
						flags.done = 1'b1;
						n_close    = ahm_pkg::CLOSE_NONE;
						n_ones     = '0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// state advances once per accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= '0;
			nrzi_q     <= 1'b1;
			ones_q     <= '0;
			crc_q      <= ahm_pkg::CRC_INIT;
			fcs_q      <= '0;
			shift_q    <= '0;
			bits_q     <= '0;
			stuff_en_q <= 1'b0;
			pend_q     <= 1'b0;
			count_q    <= '0;
			close_q    <= ahm_pkg::CLOSE_NONE;
		end else if (mid_push) begin
			phase_q    <= n_phase;
			nrzi_q     <= n_nrzi;
			ones_q     <= n_ones;
			crc_q      <= n_crc;
			fcs_q      <= n_fcs;
			shift_q    <= n_shift;
			bits_q     <= n_bits;
			stuff_en_q <= n_stuff_en;
			pend_q     <= n_pend;
			count_q    <= n_count;
			close_q    <= n_close;
		end
	end

endmodule

// ----- sv/ahm_tone.sv -----
// Back part: sine lookup, amplitude scaling and divide by full scale, 3 stages.
module ahm_tone #(
	parameter int PHASE_WIDTH = 32,
	parameter int OUT_DEPTH   = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [PHASE_WIDTH-1:0]        in_phase,
	input  ahm_pkg::flags_t               in_flags,
	output logic                          in_pull,
	input  logic [ahm_pkg::MAG_W-1:0]     amplitude,
	input  logic                          out_pop,
	output logic                          out_valid,
	output logic [ahm_pkg::SAMPLE_W-1:0]  out_sample,
	output ahm_pkg::flags_t               out_flags
);

	localparam int OCC_W = $clog2(OUT_DEPTH + 1);

	logic [OCC_W-1:0]                occ_q;
	logic [ahm_pkg::POS_BITS-1:0]    pos;
	logic [ahm_pkg::SINE_BITS-1:0]   idx;
	logic                            valid_s1, valid_s2, valid_s3;
	ahm_pkg::flags_t                 flags_s1, flags_s2, flags_s3;
	logic                            neg_s1, neg_s2;
	logic [ahm_pkg::MAG_W-1:0]       mag_s1;
	logic [ahm_pkg::PROD_W-1:0]      prod_s2;
	logic [ahm_pkg::MAG_W:0]         q0, rem, quot;
	logic [ahm_pkg::SAMPLE_W-1:0]    sample_s3;

	// words in flight plus words in the output queue never exceed its depth
	assign in_pull = in_valid && ((occ_q != OCC_W'(OUT_DEPTH)) || out_pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (in_pull && !out_pop) begin
			occ_q <= occ_q + 1'b1;
		end else if (out_pop && !in_pull) begin
			occ_q <= occ_q - 1'b1;
		end
	end

	// quadrant fold of the table index
	assign pos = in_phase[PHASE_WIDTH-1 -: ahm_pkg::POS_BITS];
	assign idx = pos[ahm_pkg::POS_BITS-2] ? ~pos[ahm_pkg::SINE_BITS-1:0] :
		pos[ahm_pkg::SINE_BITS-1:0];

	// divide by 32767: x = q0*32767 + (q0 + low bits), remainder below 2*32767
	assign q0   = {1'b0, prod_s2[ahm_pkg::PROD_W-1 -: ahm_pkg::MAG_W]};
	assign rem  = {1'b0, prod_s2[ahm_pkg::MAG_W-1:0]} + q0;
	assign quot = (rem >= ahm_pkg::FULL_SCALE) ? q0 + 1'b1 : q0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= in_pull;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// payload stages
	always_ff @(posedge clk) begin
		flags_s1  <= in_flags;
		neg_s1    <= pos[ahm_pkg::POS_BITS-1];
		mag_s1    <= in_flags.active ? ahm_pkg::QUARTER_SINE[idx] : '0;
		flags_s2  <= flags_s1;
		neg_s2    <= neg_s1;
		prod_s2   <= ahm_pkg::PROD_W'(mag_s1) * ahm_pkg::PROD_W'(amplitude);
		flags_s3  <= flags_s2;
		sample_s3 <= neg_s2 ? -quot : quot;
	end

	assign out_valid  = valid_s3;
	assign out_sample = sample_s3;
	assign out_flags  = flags_s3;

endmodule

// ----- sv/afsk_hdlc_modulator.sv -----
// Top level of the Bell 202 AFSK modulator with HDLC framing and NRZI coding.
// One input word is one audio sample tick and yields exactly one result word.
// The front part takes a word per clock whenever its small queue has room, so
// the sustained rate is one word per cycle; a taken word passes the queue
// write, then the three tone stages (table lookup, 15x15 multiply, divide by
// full scale), and so reaches the output queue. The tone stages pull
// only while the output queue has a slot reserved, so a stalled reader backs
// up through the queues to full. Configuration takes effect at the next tick
// and should be written only while no word is in flight.
`include "afsk_hdlc_modulator_defines.svh"

module afsk_hdlc_modulator #(
	parameter int PHASE_WIDTH = 32,
	parameter int MID_DEPTH   = 2,
	parameter int OUT_DEPTH   = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [2:0]         cmd,
	input  logic [7:0]         data_byte,
	output logic               empty,
	input  logic               pop,
	output logic signed [15:0] sample,
	output logic               sample_active,
	output logic               cmd_taken,
	output logic               frame_done,
	input  logic               cfg_write,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	localparam int MID_W = PHASE_WIDTH + ahm_pkg::FLAGS_W;
	localparam int OUT_W = ahm_pkg::SAMPLE_W + ahm_pkg::FLAGS_W;

	logic [31:0]                   mark_step_q, space_step_q;
	logic [ahm_pkg::MAG_W-1:0]     amplitude_q;
	logic [7:0]                    sps_q;

	logic                          mid_push, mid_full, mid_empty, mid_pull;
	logic [PHASE_WIDTH-1:0]        mid_phase_in, mid_phase_out;
	ahm_pkg::flags_t               mid_flags_in, mid_flags_out;
	logic [MID_W-1:0]              mid_dout;

	logic                          out_push, out_full, out_pop;
	logic [ahm_pkg::SAMPLE_W-1:0]  tone_sample;
	ahm_pkg::flags_t               tone_flags, res_flags;
	logic [OUT_W-1:0]              out_dout;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mark_step_q  <= 32'd107374182;
			space_step_q <= 32'd196852668;
			amplitude_q  <= 15'd16384;
			sps_q        <= 8'd40;
		end else if (cfg_write) begin
			unique case (cfg_index)
				ahm_pkg::REG_MARK_STEP:  mark_step_q  <= cfg_data;
				ahm_pkg::REG_SPACE_STEP: space_step_q <= cfg_data;
				ahm_pkg::REG_AMPLITUDE:  amplitude_q  <= cfg_data[ahm_pkg::MAG_W-1:0];
				ahm_pkg::REG_SPS:        sps_q        <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	// front: framing and phase
	ahm_front #(
		.PHASE_WIDTH(PHASE_WIDTH)
	) u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.push              (push),
		.cmd               (cmd),
		.data_byte         (data_byte),
		.mid_full          (mid_full),
		.mark_step         (mark_step_q),
		.space_step        (space_step_q),
		.sym_len           (sps_q),
		.mid_push          (mid_push),
		.mid_phase         (mid_phase_in),
		.mid_flags         (mid_flags_in)
	);

	assign full = mid_full;

	// queue between front and back
	ahm_queue #(
		.WIDTH(MID_W),
		.DEPTH(MID_DEPTH)
	) u_mid_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (mid_push),
		.din   ({mid_phase_in, mid_flags_in}),
		.full  (mid_full),
		.pop   (mid_pull),
		.dout  (mid_dout),
		.empty (mid_empty)
	);

	assign mid_phase_out = mid_dout[MID_W-1 -: PHASE_WIDTH];
	assign mid_flags_out = mid_dout[ahm_pkg::FLAGS_W-1:0];

	// back: tone synthesis
	ahm_tone #(
		.PHASE_WIDTH(PHASE_WIDTH),
		.OUT_DEPTH  (OUT_DEPTH)
	) u_tone (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (!mid_empty),
		.in_phase  (mid_phase_out),
		.in_flags  (mid_flags_out),
		.in_pull   (mid_pull),
		.amplitude (amplitude_q),
		.out_pop   (out_pop),
		.out_valid (out_push),
		.out_sample(tone_sample),
		.out_flags (tone_flags)
	);

	assign out_pop = pop && !empty;

	// result queue
	ahm_queue #(
		.WIDTH(OUT_W),
		.DEPTH(OUT_DEPTH)
	) u_out_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (out_push),
		.din   ({tone_sample, tone_flags}),
		.full  (out_full),
		.pop   (pop),
		.dout  (out_dout),
		.empty (empty)
	);

	assign res_flags     = out_dout[ahm_pkg::FLAGS_W-1:0];
	assign sample        = $signed(out_dout[OUT_W-1 -: ahm_pkg::SAMPLE_W]);
	assign sample_active = res_flags.active;
	assign cmd_taken     = res_flags.taken;
	assign frame_done    = res_flags.done;

	// checks
	`AHM_ASSERT_IMP(a_no_out_overflow, out_push, !out_full, "result queue overflow")
	`AHM_ASSERT_NEXT(a_out_holds_word, out_push, !empty, "pushed result vanished")
	`AHM_ASSERT_IMP(a_idle_silent, !empty && !sample_active, sample == 16'sd0,
		"idle tick with nonzero sample")
	`AHM_ASSERT_IMP(a_done_active, !empty && frame_done, sample_active,
		"frame end outside a symbol")

endmodule
